// File: sv/affw_pkg.sv
// Shared types and codes for the affine warp interpolator.
// Used by affw_map, affw_store, affw_interp and the top level.
package affw_pkg;

  localparam int COEF_W = 32;
  localparam int POS_W  = 16;
  localparam int PIX_W  = 8;

  // command codes
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // interpolation modes; any other code acts as bicubic
  localparam logic [1:0] MODE_NEAREST  = 2'd0;
  localparam logic [1:0] MODE_BILINEAR = 2'd1;
  localparam logic [1:0] MODE_BICUBIC  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_U_OFFSET   = 3'd0;
  localparam logic [2:0] REG_U_X        = 3'd1;
  localparam logic [2:0] REG_U_Y        = 3'd2;
  localparam logic [2:0] REG_V_OFFSET   = 3'd3;
  localparam logic [2:0] REG_V_X        = 3'd4;
  localparam logic [2:0] REG_V_Y        = 3'd5;
  localparam logic [2:0] REG_INTERP     = 3'd6;
  localparam logic [2:0] REG_BACKGROUND = 3'd7;

  typedef struct packed {
    logic                    cmd;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [PIX_W-1:0]        pixel_in;
  } affw_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             outside;
  } affw_out_t;

  // per-item control that travels with the pipeline
  typedef struct packed {
    logic       is_load;
    logic       in_frame;
    logic [1:0] mode;
  } affw_ctl_t;

endpackage

// File: sv/affw_map.sv
// Coordinate mapping: affine transform, floor/round and frame bound checks.
// Three register stages; uses affw_pkg.
module affw_map #(
  parameter int IN_WIDTH  = 256,
  parameter int IN_HEIGHT = 256,
  parameter int FRAC_BITS = 16,
  localparam int CB = $clog2(IN_WIDTH),
  localparam int RB = $clog2(IN_HEIGHT)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic signed [31:0]             coef_u_offset_i,
  input  logic signed [31:0]             coef_u_x_i,
  input  logic signed [31:0]             coef_u_y_i,
  input  logic signed [31:0]             coef_v_offset_i,
  input  logic signed [31:0]             coef_v_x_i,
  input  logic signed [31:0]             coef_v_y_i,
  input  logic [1:0]                     mode_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  affw_pkg::affw_in_t             in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output affw_pkg::affw_ctl_t            out_ctl_o,
  output logic [CB-1:0]                  out_col_o,
  output logic [RB-1:0]                  out_row_o,
  output logic [FRAC_BITS-1:0]           out_du_o,
  output logic [FRAC_BITS-1:0]           out_dv_o,
  output logic [7:0]                     out_pixel_o
);
  import affw_pkg::*;

  localparam int N  = 3;
  localparam int PW = 48;
  localparam int UW = 50;
  localparam logic signed [UW-1:0] HALF_U = UW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [UW-1:0] LIM_W1 = UW'(IN_WIDTH - 1);
  localparam logic signed [UW-1:0] LIM_W2 = UW'(IN_WIDTH - 2);
  localparam logic signed [UW-1:0] LIM_W3 = UW'(IN_WIDTH - 3);
  localparam logic signed [UW-1:0] LIM_H1 = UW'(IN_HEIGHT - 1);
  localparam logic signed [UW-1:0] LIM_H2 = UW'(IN_HEIGHT - 2);
  localparam logic signed [UW-1:0] LIM_H3 = UW'(IN_HEIGHT - 3);

  logic [N-1:0] v_q;
  logic [N-1:0] en;

  // stage 0: products
  logic signed [PW-1:0] pux_d, puy_d, pvx_d, pvy_d;
  logic signed [PW-1:0] pux_q, puy_q, pvx_q, pvy_q;
  affw_in_t             it0_q;
  // stage 1: sums
  logic signed [UW-1:0] u_d, v_d, u_q, v_q1;
  affw_in_t             it1_q;
  // stage 2: map result
  affw_ctl_t            ctl_d, ctl_q;
  logic [CB-1:0]        col_d, col_q;
  logic [RB-1:0]        row_d, row_q;
  logic [FRAC_BITS-1:0] du_q, dv_q;
  logic [7:0]           pix_q;

  // stall chain
  always_comb begin
    en[N-1] = !v_q[N-1] || !out_stall_i;
    for (int k = N - 2; k >= 0; k--) en[k] = !v_q[k] || en[k+1];
  end
  assign in_stall_o = !en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < N; k++) if (en[k]) v_q[k] <= v_q[k-1];
    end
  end

  assign pux_d = coef_u_x_i * $signed(in_item_i.pos_x);
  assign puy_d = coef_u_y_i * $signed(in_item_i.pos_y);
  assign pvx_d = coef_v_x_i * $signed(in_item_i.pos_x);
  assign pvy_d = coef_v_y_i * $signed(in_item_i.pos_y);

  assign u_d = coef_u_offset_i + pux_q + puy_q;
  assign v_d = coef_v_offset_i + pvx_q + pvy_q;

  // floor / round and bound check per mode
  always_comb begin
    logic signed [UW-1:0] cu, cv, cn, rn;
    cu = u_q >>> FRAC_BITS;
    cv = v_q1 >>> FRAC_BITS;
    cn = (u_q + HALF_U) >>> FRAC_BITS;
    rn = (v_q1 + HALF_U) >>> FRAC_BITS;
    ctl_d.is_load = (it1_q.cmd == CMD_LOAD);
    ctl_d.mode    = mode_i;
    if (it1_q.cmd == CMD_LOAD) begin
      ctl_d.in_frame = (it1_q.pos_x >= 0) && (it1_q.pos_x < IN_WIDTH) &&
                       (it1_q.pos_y >= 0) && (it1_q.pos_y < IN_HEIGHT);
      col_d = it1_q.pos_x[CB-1:0];
      row_d = it1_q.pos_y[RB-1:0];
    end else begin
      case (mode_i)
        MODE_NEAREST: begin
          ctl_d.in_frame = !cn[UW-1] && (cn <= LIM_W1) && !rn[UW-1] && (rn <= LIM_H1);
          col_d = cn[CB-1:0];
          row_d = rn[RB-1:0];
        end
        MODE_BILINEAR: begin
          ctl_d.in_frame = !cu[UW-1] && (cu <= LIM_W2) && !cv[UW-1] && (cv <= LIM_H2);
          col_d = cu[CB-1:0];
          row_d = cv[RB-1:0];
        end
        default: begin
          ctl_d.in_frame = !cu[UW-1] && (cu != '0) && (cu <= LIM_W3) &&
                           !cv[UW-1] && (cv != '0) && (cv <= LIM_H3);
          col_d = cu[CB-1:0] - CB'(1);
          row_d = cv[RB-1:0] - RB'(1);
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      it0_q <= in_item_i;
      pux_q <= pux_d;
      puy_q <= puy_d;
      pvx_q <= pvx_d;
      pvy_q <= pvy_d;
    end
    if (en[1]) begin
      it1_q <= it0_q;
      u_q   <= u_d;
      v_q1  <= v_d;
    end
    if (en[2]) begin
      ctl_q <= ctl_d;
      col_q <= col_d;
      row_q <= row_d;
      du_q  <= u_q[FRAC_BITS-1:0];
      dv_q  <= v_q1[FRAC_BITS-1:0];
      pix_q <= it1_q.pixel_in;
    end
  end

  assign out_valid_o = v_q[N-1];
  assign out_ctl_o   = ctl_q;
  assign out_col_o   = col_q;
  assign out_row_o   = row_q;
  assign out_du_o    = du_q;
  assign out_dv_o    = dv_q;
  assign out_pixel_o = pix_q;

`ifndef SYNTHESIS
  // a bicubic window must lie fully inside the frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ctl_o.is_load && out_ctl_o.in_frame &&
    (out_ctl_o.mode != MODE_NEAREST) && (out_ctl_o.mode != MODE_BILINEAR)
    |-> (out_col_o <= CB'(IN_WIDTH - 4)) && (out_row_o <= RB'(IN_HEIGHT - 4)))
    else $error("bicubic window origin out of range");
  // a bilinear window must lie fully inside the frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ctl_o.is_load && out_ctl_o.in_frame &&
    (out_ctl_o.mode == MODE_BILINEAR)
    |-> (out_col_o <= CB'(IN_WIDTH - 2)) && (out_row_o <= RB'(IN_HEIGHT - 2)))
    else $error("bilinear window origin out of range");
`endif

endmodule

// File: sv/affw_store.sv
// Frame store in 16 banks interleaved by column and row modulo four, so any
// 4x4 window reads each bank once. One register stage; uses affw_pkg.
module affw_store #(
  parameter int IN_WIDTH  = 256,
  parameter int IN_HEIGHT = 256,
  parameter int FRAC_BITS = 16,
  localparam int CB = $clog2(IN_WIDTH),
  localparam int RB = $clog2(IN_HEIGHT)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  affw_pkg::affw_ctl_t     in_ctl_i,
  input  logic [CB-1:0]           in_col_i,
  input  logic [RB-1:0]           in_row_i,
  input  logic [FRAC_BITS-1:0]    in_du_i,
  input  logic [FRAC_BITS-1:0]    in_dv_i,
  input  logic [7:0]              in_pixel_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output affw_pkg::affw_ctl_t     out_ctl_o,
  output logic [3:0][3:0][7:0]    out_win_o,
  output logic [FRAC_BITS-1:0]    out_du_o,
  output logic [FRAC_BITS-1:0]    out_dv_o
);
  import affw_pkg::*;

  localparam int WB    = (IN_WIDTH + 3) / 4;
  localparam int HB    = (IN_HEIGHT + 3) / 4;
  localparam int DEPTH = WB * HB;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                 en;
  logic                 v_q;
  affw_ctl_t            ctl_q;
  logic [1:0]           col_ph_q, row_ph_q;
  logic [FRAC_BITS-1:0] du_q, dv_q;
  logic [3:0][3:0][7:0] rd_all;
  logic [15:0]          bank_we;

  assign en         = !v_q || !out_stall_i;
  assign in_stall_o = !en;

  // one bank per column/row phase
  for (genvar bi = 0; bi < 4; bi++) begin : g_row
    for (genvar bj = 0; bj < 4; bj++) begin : g_col
      logic [1:0]    oi, oj;
      logic [RB:0]   roww;
      logic [CB:0]   colw;
      logic [AW-1:0] addr;
      logic [7:0]    bank_mem [DEPTH];
      logic [7:0]    rd_q;

      assign oi   = 2'(bi) - in_row_i[1:0];
      assign oj   = 2'(bj) - in_col_i[1:0];
      assign roww = {1'b0, in_row_i} + (RB+1)'(oi);
      assign colw = {1'b0, in_col_i} + (CB+1)'(oj);
      assign addr = AW'(32'(roww[RB:2]) * WB + 32'(colw[CB:2]));
      // a load touches only the bank of its own phase
      assign bank_we[bi*4+bj] = en && in_valid_i && in_ctl_i.is_load && in_ctl_i.in_frame &&
                                (oi == 2'd0) && (oj == 2'd0);

      always_ff @(posedge clk_i) begin
        if (bank_we[bi*4+bj]) bank_mem[addr] <= in_pixel_i;
        if (en) rd_q <= bank_mem[addr];
      end
      assign rd_all[bi][bj] = rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= in_valid_i && !in_ctl_i.is_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctl_q    <= in_ctl_i;
      col_ph_q <= in_col_i[1:0];
      row_ph_q <= in_row_i[1:0];
      du_q     <= in_du_i;
      dv_q     <= in_dv_i;
    end
  end

  // rotate bank outputs into window order
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        out_win_o[r][c] = rd_all[2'(row_ph_q + 2'(r))][2'(col_ph_q + 2'(c))];
      end
    end
  end

  assign out_valid_o = v_q;
  assign out_ctl_o   = ctl_q;
  assign out_du_o    = du_q;
  assign out_dv_o    = dv_q;

`ifndef SYNTHESIS
  // a load writes a single bank
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(bank_we))
    else $error("more than one bank written");
`endif

endmodule

// File: sv/affw_interp.sv
// Interpolation datapath: bicubic row and column cubics, bilinear blend,
// nearest pass-through and the result register. Eight stages; uses affw_pkg.
module affw_interp #(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [7:0]             background_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  affw_pkg::affw_ctl_t    in_ctl_i,
  input  logic [3:0][3:0][7:0]   in_win_i,
  input  logic [FRAC_BITS-1:0]   in_du_i,
  input  logic [FRAC_BITS-1:0]   in_dv_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output affw_pkg::affw_out_t    out_item_o
);
  import affw_pkg::*;

  localparam int N  = 8;
  localparam int F  = FRAC_BITS;
  localparam int CW = F + 18;
  localparam int MW = CW + F + 1;
  localparam logic signed [MW-1:0] HALF_M = MW'(1) <<< (F - 1);
  localparam logic signed [CW-1:0] HALF_C = CW'(1) <<< (F - 1);
  localparam logic signed [CW-1:0] MAX_C  = CW'(255) <<< F;

  // round-half-up of d*t/S
  function automatic logic signed [CW-1:0] mf(input logic [F-1:0] d,
                                              input logic signed [CW-1:0] t);
    logic signed [MW-1:0] p;
    p = $signed({1'b0, d}) * t;
    p = p + HALF_M;
    return CW'(p >>> F);
  endfunction

  logic [N-1:0] v_q;
  logic [N-1:0] en;
  affw_ctl_t    ctl_q [N-1];
  logic [F-1:0] du_q [2];
  logic [F-1:0] dv_q [6];
  logic [7:0]   near_q [7];

  // row cubic stages
  logic signed [CW-1:0] t1_d [4], t1_q [4];
  logic signed [9:0]    p2_d [4], p2_q [4];
  logic [7:0]           f1_q [4], f1b_q [4];
  logic signed [CW-1:0] t2_d [4], t2_q [4];
  logic signed [CW-1:0] row_d [4], row_q [4];
  // bilinear
  logic signed [CW-1:0] top_d, bot_d, top_q, bot_q, cbl_d, cbl_q;
  logic signed [CW-1:0] bls;
  logic [7:0]           bl_q [5];
  // column cubic stages
  logic signed [CW-1:0] cp2_q, cp3_q, cp4_q, r1_q;
  logic signed [CW-1:0] ct1_q, cp2b_q, r1b_q;
  logic signed [CW-1:0] ct2_q, r1c_q;
  logic signed [CW-1:0] c_q;
  logic signed [CW-1:0] csum;
  logic [7:0]           cub;
  affw_out_t            res_d, res_q;

  always_comb begin
    en[N-1] = !v_q[N-1] || !out_stall_i;
    for (int k = N - 2; k >= 0; k--) en[k] = !v_q[k] || en[k+1];
  end
  assign in_stall_o = !en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < N; k++) if (en[k]) v_q[k] <= v_q[k-1];
    end
  end

  // first row term and bilinear horizontal blend
  always_comb begin
    logic signed [9:0]  f0, f1, f2, f3;
    logic signed [10:0] p3, p4;
    logic signed [8:0]  dt, db;
    for (int k = 0; k < 4; k++) begin
      f0 = $signed({2'b00, in_win_i[k][0]});
      f1 = $signed({2'b00, in_win_i[k][1]});
      f2 = $signed({2'b00, in_win_i[k][2]});
      f3 = $signed({2'b00, in_win_i[k][3]});
      p4 = 11'(-f0 + f1 - f2 + f3);
      p3 = 11'(2 * f0 - 2 * f1 + f2 - f3);
      p2_d[k] = f2 - f0;
      t1_d[k] = (CW'(p3) <<< F) + $signed({1'b0, in_du_i}) * p4;
    end
    dt = $signed({1'b0, in_win_i[0][1]}) - $signed({1'b0, in_win_i[0][0]});
    db = $signed({1'b0, in_win_i[1][1]}) - $signed({1'b0, in_win_i[1][0]});
    top_d = $signed(CW'(in_win_i[0][0]) <<< F) + $signed({1'b0, in_du_i}) * dt;
    bot_d = $signed(CW'(in_win_i[1][0]) <<< F) + $signed({1'b0, in_du_i}) * db;
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      t2_d[k]  = (CW'(p2_q[k]) <<< F) + mf(du_q[0], t1_q[k]);
      row_d[k] = $signed(CW'(f1b_q[k]) <<< F) + mf(du_q[1], t2_q[k]);
    end
    cbl_d = top_q + mf(dv_q[0], bot_q - top_q);
    bls   = cbl_q + HALF_C;
  end

  // clamp and round the bicubic result
  always_comb begin
    csum = c_q + HALF_C;
    if (c_q[CW-1]) cub = 8'd0;
    else if (c_q > MAX_C) cub = 8'd255;
    else cub = csum[F+7:F];
  end

  // final select
  always_comb begin
    if (!ctl_q[6].in_frame) begin
      res_d.pixel_out = background_i;
      res_d.outside   = 1'b1;
    end else begin
      res_d.outside = 1'b0;
      case (ctl_q[6].mode)
        MODE_NEAREST:  res_d.pixel_out = near_q[6];
        MODE_BILINEAR: res_d.pixel_out = bl_q[4];
        default:       res_d.pixel_out = cub;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      ctl_q[0]  <= in_ctl_i;
      du_q[0]   <= in_du_i;
      dv_q[0]   <= in_dv_i;
      near_q[0] <= in_win_i[0][0];
      top_q     <= top_d;
      bot_q     <= bot_d;
      for (int k = 0; k < 4; k++) begin
        t1_q[k] <= t1_d[k];
        p2_q[k] <= p2_d[k];
        f1_q[k] <= in_win_i[k][1];
      end
    end
    if (en[1]) begin
      ctl_q[1]  <= ctl_q[0];
      du_q[1]   <= du_q[0];
      dv_q[1]   <= dv_q[0];
      near_q[1] <= near_q[0];
      cbl_q     <= cbl_d;
      for (int k = 0; k < 4; k++) begin
        t2_q[k]  <= t2_d[k];
        f1b_q[k] <= f1_q[k];
      end
    end
    if (en[2]) begin
      ctl_q[2]  <= ctl_q[1];
      dv_q[2]   <= dv_q[1];
      near_q[2] <= near_q[1];
      bl_q[0]   <= bls[F+7:F];
      for (int k = 0; k < 4; k++) row_q[k] <= row_d[k];
    end
    if (en[3]) begin
      ctl_q[3]  <= ctl_q[2];
      dv_q[3]   <= dv_q[2];
      near_q[3] <= near_q[2];
      bl_q[1]   <= bl_q[0];
      cp2_q <= row_q[2] - row_q[0];
      cp3_q <= 2 * row_q[0] - 2 * row_q[1] + row_q[2] - row_q[3];
      cp4_q <= -row_q[0] + row_q[1] - row_q[2] + row_q[3];
      r1_q  <= row_q[1];
    end
    if (en[4]) begin
      ctl_q[4]  <= ctl_q[3];
      dv_q[4]   <= dv_q[3];
      near_q[4] <= near_q[3];
      bl_q[2]   <= bl_q[1];
      ct1_q  <= cp3_q + mf(dv_q[3], cp4_q);
      cp2b_q <= cp2_q;
      r1b_q  <= r1_q;
    end
    if (en[5]) begin
      ctl_q[5]  <= ctl_q[4];
      dv_q[5]   <= dv_q[4];
      near_q[5] <= near_q[4];
      bl_q[3]   <= bl_q[2];
      ct2_q <= cp2b_q + mf(dv_q[4], ct1_q);
      r1c_q <= r1b_q;
    end
    if (en[6]) begin
      ctl_q[6]  <= ctl_q[5];
      near_q[6] <= near_q[5];
      bl_q[4]   <= bl_q[3];
      c_q <= r1c_q + mf(dv_q[5], ct2_q);
    end
    if (en[7]) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = v_q[N-1];
  assign out_item_o  = res_q;

`ifndef SYNTHESIS
  // an outside result carries the background value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.outside |-> out_item_o.pixel_out == background_i)
    else $error("outside result without background value");
  // a held result stays in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(res_q))
    else $error("result register changed while held");
`endif

endmodule

// File: sv/affine_warp_interpolator_unit.sv
// Affine warp interpolator top level: configuration registers and pipeline.
// Pipeline: 12 register stages; loads give no result.
// Throughput: one item per cycle in every mode while the output is not stalled;
// 16 frame store banks give a full 4x4 window in one read, one port per bank.
// Reset: asynchronous active low; clears configuration registers to defaults and
// pipeline valids; the frame store is not cleared. Uses affw_pkg, affw_map/store/interp.
module affine_warp_interpolator_unit #(
  parameter int IN_WIDTH  = 256,
  parameter int IN_HEIGHT = 256,
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  affw_pkg::affw_in_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output affw_pkg::affw_out_t  out_item_o,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [31:0]          cfg_data_i
);
  import affw_pkg::*;

  localparam int CB = $clog2(IN_WIDTH);
  localparam int RB = $clog2(IN_HEIGHT);
  localparam logic [31:0] ONE_FX = 32'(1) << FRAC_BITS;

  logic signed [31:0] u_off_q, u_x_q, u_y_q, v_off_q, v_x_q, v_y_q;
  logic [1:0]         mode_q;
  logic [7:0]         bg_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_off_q <= '0;
      u_x_q   <= ONE_FX;
      u_y_q   <= '0;
      v_off_q <= '0;
      v_x_q   <= '0;
      v_y_q   <= ONE_FX;
      mode_q  <= MODE_BILINEAR;
      bg_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_U_OFFSET:   u_off_q <= cfg_data_i;
        REG_U_X:        u_x_q   <= cfg_data_i;
        REG_U_Y:        u_y_q   <= cfg_data_i;
        REG_V_OFFSET:   v_off_q <= cfg_data_i;
        REG_V_X:        v_x_q   <= cfg_data_i;
        REG_V_Y:        v_y_q   <= cfg_data_i;
        REG_INTERP:     mode_q  <= cfg_data_i[1:0];
        REG_BACKGROUND: bg_q    <= cfg_data_i[7:0];
        default:        ;
      endcase
    end
  end

  logic                 map_valid, map_stall;
  affw_ctl_t            map_ctl;
  logic [CB-1:0]        map_col;
  logic [RB-1:0]        map_row;
  logic [FRAC_BITS-1:0] map_du, map_dv;
  logic [7:0]           map_pix;

  logic                 st_valid, st_stall;
  affw_ctl_t            st_ctl;
  logic [3:0][3:0][7:0] st_win;
  logic [FRAC_BITS-1:0] st_du, st_dv;

  affw_map #(
    .IN_WIDTH (IN_WIDTH),
    .IN_HEIGHT(IN_HEIGHT),
    .FRAC_BITS(FRAC_BITS)
  ) u_map (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .coef_u_offset_i(u_off_q),
    .coef_u_x_i     (u_x_q),
    .coef_u_y_i     (u_y_q),
    .coef_v_offset_i(v_off_q),
    .coef_v_x_i     (v_x_q),
    .coef_v_y_i     (v_y_q),
    .mode_i         (mode_q),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_item_i      (in_item_i),
    .out_valid_o    (map_valid),
    .out_stall_i    (map_stall),
    .out_ctl_o      (map_ctl),
    .out_col_o      (map_col),
    .out_row_o      (map_row),
    .out_du_o       (map_du),
    .out_dv_o       (map_dv),
    .out_pixel_o    (map_pix)
  );

  affw_store #(
    .IN_WIDTH (IN_WIDTH),
    .IN_HEIGHT(IN_HEIGHT),
    .FRAC_BITS(FRAC_BITS)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (map_valid),
    .in_stall_o (map_stall),
    .in_ctl_i   (map_ctl),
    .in_col_i   (map_col),
    .in_row_i   (map_row),
    .in_du_i    (map_du),
    .in_dv_i    (map_dv),
    .in_pixel_i (map_pix),
    .out_valid_o(st_valid),
    .out_stall_i(st_stall),
    .out_ctl_o  (st_ctl),
    .out_win_o  (st_win),
    .out_du_o   (st_du),
    .out_dv_o   (st_dv)
  );

  affw_interp #(
    .FRAC_BITS(FRAC_BITS)
  ) u_interp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .background_i(bg_q),
    .in_valid_i  (st_valid),
    .in_stall_o  (st_stall),
    .in_ctl_i    (st_ctl),
    .in_win_i    (st_win),
    .in_du_i     (st_du),
    .in_dv_i     (st_dv),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// File: bench/tb_affine_warp_interpolator_unit.sv
// Self-checking testbench for affine_warp_interpolator_unit: loads source
// pixels, samples warped pixels in all modes and checks them against a
// fixed-point predictor. Depends on affw_pkg and the unit's RTL.
`timescale 1ns / 1ps

module tb_affine_warp_interpolator_unit;
  import affw_pkg::*;

  localparam int  W      = 256;
  localparam int  H      = 256;
  localparam int  FB     = 16;
  localparam longint ONE  = longint'(1) << FB;
  localparam longint HALF = longint'(1) << (FB - 1);
  localparam int  LIMIT  = 600000;
  localparam int  LAT    = 12;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_stall;
  affw_in_t    in_item;
  logic        out_valid;
  logic        out_stall;
  affw_out_t   out_item;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [31:0] cfg_data;

  affine_warp_interpolator_unit #(
    .IN_WIDTH(W), .IN_HEIGHT(H), .FRAC_BITS(FB)
  ) u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_item_i(in_item),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_item_o(out_item),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  // predictor state: coefficients, mode, background and a frame copy
  longint     coef[6];
  logic [1:0] warp_mode;
  logic [7:0] bg_pix;
  logic [7:0] frame_copy[W*H];
  bit         loaded[W*H];     // entries written by the stimulus so far

  affw_in_t   pending_items[$];
  affw_out_t  expected_pix[$];
  int         errors;
  int         cycles;
  bit         idle_en;
  bit         hold_req;
  bit         in_taken;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // mismatch report
  task automatic report(input string what);
    errors++;
    $display("mismatch at cycle %0d: %s", cycles, what);
  endtask

  // d*b/S rounded half up, 0 <= d < S
  function automatic longint mul_frac(input longint d, input longint b);
    longint hi, lo;
    hi = b >>> FB;
    lo = b - hi * ONE;
    return d * hi + ((d * lo + HALF) >>> FB);
  endfunction

  function automatic longint cubic(input longint f0, input longint f1,
                                   input longint f2, input longint f3,
                                   input longint d);
    longint p2, p3, p4, t;
    p2 = f2 - f0;
    p3 = 2 * f0 - 2 * f1 + f2 - f3;
    p4 = -f0 + f1 - f2 + f3;
    t  = p3 + mul_frac(d, p4);
    t  = p2 + mul_frac(d, t);
    return f1 + mul_frac(d, t);
  endfunction

  // source coordinates of an output position, Q16.16
  function automatic void map_pos(input longint x, input longint y,
                                  output longint u, output longint v);
    u = coef[0] + coef[1] * x + coef[2] * y;
    v = coef[3] + coef[4] * x + coef[5] * y;
  endfunction

  // window origin and size read by a sample; size 0 when outside
  function automatic void footprint(input longint x, input longint y,
                                    output longint c0, output longint r0,
                                    output int n);
    longint u, v, cu, cv;
    map_pos(x, y, u, v);
    n = 0;
    if (warp_mode == MODE_NEAREST) begin
      cu = (u + HALF) >>> FB;
      cv = (v + HALF) >>> FB;
      if (cu >= 0 && cu < W && cv >= 0 && cv < H) n = 1;
      c0 = cu; r0 = cv;
    end else if (warp_mode == MODE_BILINEAR) begin
      cu = u >>> FB;
      cv = v >>> FB;
      if (cu >= 0 && cu <= W - 2 && cv >= 0 && cv <= H - 2) n = 2;
      c0 = cu; r0 = cv;
    end else begin
      cu = u >>> FB;
      cv = v >>> FB;
      if (cu >= 1 && cu <= W - 3 && cv >= 1 && cv <= H - 3) n = 4;
      c0 = cu - 1; r0 = cv - 1;
    end
  endfunction

  // true when every entry the sample would read has been loaded
  function automatic bit taps_loaded(input longint x, input longint y);
    longint c0, r0;
    int n;
    footprint(x, y, c0, r0, n);
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++)
        if (!loaded[(r0 + r) * W + c0 + c]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic longint px(input longint c, input longint r);
    return longint'(frame_copy[r * W + c]);
  endfunction

  // expected output pixel of a sample
  function automatic affw_out_t warp_pixel(input longint x, input longint y);
    affw_out_t o;
    longint u, v, cu, cv, du, dv, top, bot, c;
    longint rows[4];
    map_pos(x, y, u, v);
    o.pixel_out = bg_pix;
    o.outside   = 1'b1;
    if (warp_mode == MODE_NEAREST) begin
      cu = (u + HALF) >>> FB;
      cv = (v + HALF) >>> FB;
      if (cu >= 0 && cu < W && cv >= 0 && cv < H) begin
        o.pixel_out = frame_copy[cv * W + cu];
        o.outside   = 1'b0;
      end
    end else begin
      cu = u >>> FB;
      cv = v >>> FB;
      du = u - cu * ONE;
      dv = v - cv * ONE;
      if (warp_mode == MODE_BILINEAR) begin
        if (cu >= 0 && cu <= W - 2 && cv >= 0 && cv <= H - 2) begin
          top = px(cu, cv) * ONE + du * (px(cu + 1, cv) - px(cu, cv));
          bot = px(cu, cv + 1) * ONE + du * (px(cu + 1, cv + 1) - px(cu, cv + 1));
          c   = top + mul_frac(dv, bot - top);
          o.pixel_out = 8'((c + HALF) >>> FB);
          o.outside   = 1'b0;
        end
      end else if (cu >= 1 && cu <= W - 3 && cv >= 1 && cv <= H - 3) begin
        for (int k = 0; k < 4; k++)
          rows[k] = cubic(px(cu - 1, cv - 1 + k) * ONE, px(cu, cv - 1 + k) * ONE,
                          px(cu + 1, cv - 1 + k) * ONE, px(cu + 2, cv - 1 + k) * ONE,
                          du);
        c = cubic(rows[0], rows[1], rows[2], rows[3], dv);
        if (c < 0) c = 0;
        if (c > 255 * ONE) c = 255 * ONE;
        o.pixel_out = 8'((c + HALF) >>> FB);
        o.outside   = 1'b0;
      end
    end
    return o;
  endfunction

  // stimulus helpers
  task automatic add_load(input int x, input int y, input logic [7:0] p);
    affw_in_t it;
    it.cmd = CMD_LOAD; it.pos_x = 16'(x); it.pos_y = 16'(y); it.pixel_in = p;
    if (x >= 0 && x < W && y >= 0 && y < H) loaded[y * W + x] = 1'b1;
    pending_items.push_back(it);
  endtask

  // queues a sample if its reads are safe; returns whether it did
  function automatic bit add_sample(input int x, input int y);
    affw_in_t it;
    if (!taps_loaded(x, y)) return 1'b0;
    it.cmd = CMD_SAMPLE; it.pos_x = 16'(x); it.pos_y = 16'(y);
    it.pixel_in = 8'($urandom);
    pending_items.push_back(it);
    return 1'b1;
  endfunction

  task automatic load_block(input int ox, input int oy, input int n);
    logic [7:0] p;
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++) begin
        case ($urandom_range(0, 3))
          0:       p = 8'd0;
          1:       p = 8'd255;
          default: p = 8'($urandom);
        endcase
        add_load(ox + c, oy + r, p);
      end
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_we = 1'b1; cfg_idx = idx; cfg_data = data;
    @(negedge clk_i);
    cfg_we = 1'b0;
    case (idx)
      REG_INTERP:     warp_mode = data[1:0];
      REG_BACKGROUND: bg_pix = data[7:0];
      default:        coef[idx] = longint'(signed'(data));
    endcase
  endtask

  // block until every item is in and every result is out, then let loads drain
  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid || expected_pix.size() != 0)
      @(negedge clk_i);
    repeat (LAT + 8) @(negedge clk_i);
  endtask

  function automatic logic [31:0] extreme_coef();
    case ($urandom_range(0, 5))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0;
      3:       return 32'(ONE);
      4:       return 32'(-ONE);
      default: return $urandom;
    endcase
  endfunction

  // input driver: valid held until accepted, random idle bursts
  int gap_cnt;
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_item  <= '0;
      gap_cnt  = 0;
    end else if (!in_valid || in_taken) begin
      if (gap_cnt > 0) begin
        gap_cnt--;
        in_valid <= 1'b0;
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
        gap_cnt = $urandom_range(0, 14);
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        in_item  <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // accepted items update the frame copy or queue an expected pixel
  always @(posedge clk_i) begin
    in_taken = rst_ni && in_valid && !in_stall;
    if (in_taken) begin
      if (in_item.cmd == CMD_LOAD) begin
        if (in_item.pos_x >= 0 && in_item.pos_x < W && in_item.pos_y >= 0 &&
            in_item.pos_y < H)
          frame_copy[int'(in_item.pos_y) * W + int'(in_item.pos_x)] = in_item.pixel_in;
      end else begin
        expected_pix.push_back(warp_pixel(in_item.pos_x, in_item.pos_y));
      end
    end
  end

  // receiver stall: random bursts, plus one long hold on request
  int stall_cnt;
  int hold_cnt;
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      stall_cnt = 0;
      hold_cnt  = 0;
    end else if (hold_req && hold_cnt < 400) begin
      hold_cnt++;
      out_stall <= 1'b1;
    end else if (stall_cnt > 0) begin
      stall_cnt--;
      out_stall <= 1'b1;
    end else if (idle_en && $urandom_range(0, 9) == 0) begin
      stall_cnt = $urandom_range(0, 14);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    affw_out_t want;
    if (rst_ni) begin
      cycles++;
      if (out_valid && !out_stall) begin
        if (expected_pix.size() == 0) begin
          report("result with nothing expected");
        end else begin
          want = expected_pix.pop_front();
          if (out_item.pixel_out !== want.pixel_out)
            report($sformatf("pixel_out %0d, expected %0d", out_item.pixel_out,
                             want.pixel_out));
          if (out_item.outside !== want.outside)
            report($sformatf("outside %0b, expected %0b", out_item.outside,
                             want.outside));
        end
      end
      if (cycles > LIMIT) begin
        $display("timeout");
        $display("tb_affine_warp_interpolator_unit: FAIL");
        $finish;
      end
    end
  end

  // main sequence
  initial begin
    int ox, oy, tries, phase, total;
    bit ok;
    errors = 0; cycles = 0; idle_en = 1'b1; hold_req = 1'b0; in_taken = 1'b0;
    cfg_we = 1'b0; cfg_idx = '0; cfg_data = '0;
    coef[0] = 0; coef[1] = ONE; coef[2] = 0;
    coef[3] = 0; coef[4] = 0; coef[5] = ONE;
    warp_mode = MODE_BILINEAR; bg_pix = 8'd0;
    foreach (loaded[i]) loaded[i] = 1'b0;
    rst_ni = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: corner blocks, loads off the frame, samples at the edges
    load_block(0, 0, 4);
    load_block(252, 252, 4);
    add_load(-1, 0, 8'hAA);
    add_load(256, 3, 8'h55);
    add_load(-32768, 32767, 8'hFF);
    ok = add_sample(0, 0);
    ok = add_sample(254, 254);
    ok = add_sample(255, 255);
    ok = add_sample(-32768, 32767);
    wait_idle();
    cfg_write(REG_U_OFFSET, 32'(HALF));
    cfg_write(REG_V_OFFSET, 32'(HALF - 1));
    cfg_write(REG_BACKGROUND, 8'hFF);
    for (int m = 0; m < 4; m++) begin
      cfg_write(REG_INTERP, 2'(m));
      ok = add_sample(0, 0);
      ok = add_sample(1, 1);
      ok = add_sample(252, 252);
      ok = add_sample(255, 255);
      wait_idle();
    end

    // random phases; the last one runs with no idling
    total = 0;
    phase = 0;
    while (total < 1250) begin
      if (total > 1100) idle_en = 1'b0;
      ox = ($urandom_range(0, 3) == 0) ? (($urandom_range(0, 1) != 0) ? 0 : W - 8)
                                       : $urandom_range(0, W - 8);
      oy = ($urandom_range(0, 3) == 0) ? (($urandom_range(0, 1) != 0) ? 0 : H - 8)
                                       : $urandom_range(0, H - 8);
      if (phase % 4 == 3) begin
        for (int r = 0; r < 6; r++) cfg_write(3'(r), extreme_coef());
      end else begin
        cfg_write(REG_U_OFFSET, 32'(longint'(ox + 3) * ONE + $urandom_range(0, 65535)));
        cfg_write(REG_U_X, 32'(($urandom_range(0, 1) ? 1 : -1) *
                               longint'($urandom_range(32768, 98304))));
        cfg_write(REG_U_Y, 32'(longint'($urandom_range(0, 26214)) - 13107));
        cfg_write(REG_V_OFFSET, 32'(longint'(oy + 3) * ONE + $urandom_range(0, 65535)));
        cfg_write(REG_V_X, 32'(longint'($urandom_range(0, 26214)) - 13107));
        cfg_write(REG_V_Y, 32'(($urandom_range(0, 1) ? 1 : -1) *
                               longint'($urandom_range(32768, 98304))));
      end
      cfg_write(REG_INTERP, 2'($urandom_range(0, 3)));
      cfg_write(REG_BACKGROUND, 8'($urandom));
      if (phase == 2) hold_req = 1'b1;
      load_block(ox, oy, 8);
      for (int i = 0; i < 4; i++)
        add_load(int'(signed'(16'($urandom))), int'(signed'(16'($urandom))),
                 8'($urandom));
      total += 68;
      for (int i = 0; i < 60; i++) begin
        if ($urandom_range(0, 5) == 0) begin
          ok = add_sample(int'(signed'(16'($urandom))), int'(signed'(16'($urandom))));
        end else begin
          ok = 1'b0;
          tries = 0;
          while (!ok && tries < 30) begin
            ok = add_sample($urandom_range(0, 8) - 4, $urandom_range(0, 8) - 4);
            tries++;
          end
        end
        if (ok) total++;
      end
      wait_idle();
      phase++;
    end

    if (errors == 0 && expected_pix.size() == 0) begin
      $display("tb_affine_warp_interpolator_unit: PASS");
    end else begin
      if (expected_pix.size() != 0)
        $display("%0d expected results never arrived", expected_pix.size());
      $display("tb_affine_warp_interpolator_unit: FAIL");
    end
    $finish;
  end

endmodule
